@@ rtl/lsc_pkg.sv @@
package lsc_pkg;

   localparam int CW = 32;
   localparam int MAX_ROUNDS = 8;
   localparam int RW = $clog2(MAX_ROUNDS + 1);
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;

   localparam logic [3:0] OC_TOP    = 4'h1;
   localparam logic [3:0] OC_BOTTOM = 4'h2;
   localparam logic [3:0] OC_RIGHT  = 4'h4;
   localparam logic [3:0] OC_LEFT   = 4'h8;

   localparam logic [1:0] CSR_X_MIN = 2'd0;
   localparam logic [1:0] CSR_X_MAX = 2'd1;
   localparam logic [1:0] CSR_Y_MIN = 2'd2;
   localparam logic [1:0] CSR_Y_MAX = 2'd3;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
   } seg_type;

   typedef struct packed {
      coord_type x_min;
      coord_type x_max;
      coord_type y_min;
      coord_type y_max;
   } rect_type;

   function automatic logic [3:0] outcode(coord_type x, coord_type y, rect_type r);
      logic [3:0] c;
      c = '0;
      if (x > r.x_max) c |= OC_RIGHT;
      else if (x < r.x_min) c |= OC_LEFT;
      if (y > r.y_max) c |= OC_TOP;
      else if (y < r.y_min) c |= OC_BOTTOM;
      return c;
   endfunction

endpackage

@@ rtl/lsc_front.sv @@
module lsc_front
   import lsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  coord_type  req_start_x,
   input  coord_type  req_start_y,
   input  coord_type  req_end_x,
   input  coord_type  req_end_y,
   input  rect_type   rect,
   output logic       q_valid,
   input  logic       q_pop,
   output seg_type    q_seg,
   output logic [3:0] q_c0,
   output logic [3:0] q_c1
);

   // two-entry queue of segments with their entry outcodes
   seg_type    seg_ff [2];
   logic [3:0] c0_ff [2];
   logic [3:0] c1_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push;
   seg_type    s;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign s         = '{req_start_x, req_start_y, req_end_x, req_end_y};
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_seg     = seg_ff[rp_ff];
   assign q_c0      = c0_ff[rp_ff];
   assign q_c1      = c1_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         seg_ff[wp_ff] <= s;
         c0_ff[wp_ff]  <= outcode(req_start_x, req_start_y, rect);
         c1_ff[wp_ff]  <= outcode(req_end_x, req_end_y, rect);
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (q_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule

@@ rtl/lsc_divider.sv @@
module lsc_divider
   import lsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PW-1:0]        num,
   input  logic [DW-1:0]        den,
   output logic                 done,
   output logic [PW-1:0]        quo
);

   // restoring divider, one quotient bit per cycle
   localparam int CNTW = $clog2(PW + 1);

   logic [PW-1:0]   q_ff;
   logic [DW:0]     r_ff;
   logic [DW-1:0]   d_ff;
   logic [CNTW-1:0] n_ff;
   logic            busy_ff;
   logic [DW:0]     sh;
   logic [DW:0]     df;

   assign sh   = {r_ff[DW-1:0], q_ff[PW-1]};
   assign df   = sh - {1'b0, d_ff};
   assign quo  = q_ff;
   assign done = busy_ff && (n_ff == '0);

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= num;
         r_ff <= '0;
         d_ff <= den;
         n_ff <= CNTW'(PW);
      end else if (busy_ff && n_ff != '0) begin
         if (!df[DW]) begin
            r_ff <= df;
            q_ff <= {q_ff[PW-2:0], 1'b1};
         end else begin
            r_ff <= sh;
            q_ff <= {q_ff[PW-2:0], 1'b0};
         end
         n_ff <= n_ff - 1'b1;
      end
      if (reset) busy_ff <= 1'b0;
      else if (start) busy_ff <= 1'b1;
      else if (done) busy_ff <= 1'b0;
   end

endmodule

@@ rtl/lsc_back.sv @@
module lsc_back
   import lsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  rect_type   rect,
   input  logic       q_valid,
   output logic       q_pop,
   input  seg_type    q_seg,
   input  logic [3:0] q_c0,
   input  logic [3:0] q_c1,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output coord_type  rsp_out_start_x,
   output coord_type  rsp_out_start_y,
   output coord_type  rsp_out_end_x,
   output coord_type  rsp_out_end_y,
   output logic       rsp_accepted,
   output logic       rsp_first_moved,
   output logic       rsp_second_moved
);

   typedef enum logic [2:0] {
      S_IDLE, S_TEST, S_MUL, S_LOAD, S_DIV, S_SUM, S_OUT
   } state_type;

   localparam logic signed [DW+1:0] SMAX = (DW+2)'((64'sd1 <<< (CW-1)) - 64'sd1);
   localparam logic signed [DW+1:0] SMIN = -(DW+2)'(64'sd1 <<< (CW-1));
   localparam logic [PW-1:0] QCAP = PW'(64'd1 << 62);

   state_type       state_ff;
   seg_type         orig_ff, cur_ff;
   logic [3:0]      c0_ff, c1_ff;
   logic [RW-1:0]   round_ff;
   logic            first_ff, neg_ff, vert_ff;
   coord_type       edge_ff, base_ff;
   logic [DW-1:0]   ma_ff, mb_ff, md_ff;
   logic [PW-1:0]   prod_ff;
   logic            acc_ff;

   logic [3:0]      co;
   logic            vert;
   coord_type       edge_v, b0, b1, e0, e1;
   logic signed [DW-1:0] dp, cc, dd;
   logic            div_start, div_done;
   logic [PW-1:0]   quo;
   logic [PW-1:0]   qsat;
   logic signed [DW+1:0] sum;
   coord_type       res;
   coord_type       nx, ny;

   function automatic logic [DW-1:0] mag(logic signed [DW-1:0] v);
      return v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   always_comb begin
      co   = (c0_ff != 4'd0) ? c0_ff : c1_ff;
      vert = (co & (OC_RIGHT | OC_LEFT)) != 4'd0;
      if ((co & OC_RIGHT) != 4'd0) edge_v = rect.x_max;
      else if ((co & OC_LEFT) != 4'd0) edge_v = rect.x_min;
      else if ((co & OC_TOP) != 4'd0) edge_v = rect.y_max;
      else edge_v = rect.y_min;
      b0 = vert ? cur_ff.x0 : cur_ff.y0;
      b1 = vert ? cur_ff.x1 : cur_ff.y1;
      e0 = vert ? cur_ff.y0 : cur_ff.x0;
      e1 = vert ? cur_ff.y1 : cur_ff.x1;
      dp = DW'(e1) - DW'(e0);
      cc = DW'(edge_v) - DW'(b0);
      dd = DW'(b1) - DW'(b0);
   end

   assign div_start = (state_ff == S_LOAD);

   lsc_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(prod_ff), .den(md_ff), .done(div_done), .quo(quo)
   );

   always_comb begin
      qsat = (quo > QCAP) ? QCAP : quo;
      sum  = (DW+2)'(base_ff) + (neg_ff ? -(DW+2)'(qsat[DW:0]) : (DW+2)'(qsat[DW:0]));
      // quotient above the coordinate range always saturates the sum
      if (qsat > PW'(64'd1 << (CW + 1)))
         sum = neg_ff ? SMIN - 1 : SMAX + 1;
      if (md_ff == '0) res = base_ff;
      else if (sum > SMAX) res = SMAX[CW-1:0];
      else if (sum < SMIN) res = SMIN[CW-1:0];
      else res = sum[CW-1:0];
      nx = vert_ff ? edge_ff : res;
      ny = vert_ff ? res : edge_ff;
   end

   assign q_pop = (state_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (q_valid) begin
               orig_ff  <= q_seg;
               cur_ff   <= q_seg;
               c0_ff    <= q_c0;
               c1_ff    <= q_c1;
               round_ff <= '0;
               state_ff <= S_TEST;
            end
            S_TEST: begin
               if ((c0_ff | c1_ff) == 4'd0) begin
                  acc_ff   <= 1'b1;
                  state_ff <= S_OUT;
               end else if ((c0_ff & c1_ff) != 4'd0 || round_ff >= RW'(MAX_ROUNDS)) begin
                  acc_ff   <= 1'b0;
                  state_ff <= S_OUT;
               end else begin
                  first_ff <= (c0_ff != 4'd0);
                  vert_ff  <= vert;
                  edge_ff  <= edge_v;
                  base_ff  <= e0;
                  neg_ff   <= (dp[DW-1] ^ cc[DW-1]) ^ dd[DW-1];
                  ma_ff    <= mag(dp);
                  mb_ff    <= mag(cc);
                  md_ff    <= mag(dd);
                  state_ff <= S_MUL;
               end
            end
            S_MUL: state_ff <= S_LOAD;
            S_LOAD: state_ff <= S_DIV;
            S_DIV: if (div_done) state_ff <= S_SUM;
            S_SUM: begin
               if (first_ff) begin
                  cur_ff.x0 <= nx;
                  cur_ff.y0 <= ny;
                  c0_ff     <= outcode(nx, ny, rect);
               end else begin
                  cur_ff.x1 <= nx;
                  cur_ff.y1 <= ny;
                  c1_ff     <= outcode(nx, ny, rect);
               end
               round_ff <= round_ff + 1'b1;
               state_ff <= S_TEST;
            end
            S_OUT: if (!rsp_valid || !rsp_stall) begin
               rsp_valid        <= 1'b1;
               rsp_accepted     <= acc_ff;
               rsp_out_start_x  <= acc_ff ? cur_ff.x0 : orig_ff.x0;
               rsp_out_start_y  <= acc_ff ? cur_ff.y0 : orig_ff.y0;
               rsp_out_end_x    <= acc_ff ? cur_ff.x1 : orig_ff.x1;
               rsp_out_end_y    <= acc_ff ? cur_ff.y1 : orig_ff.y1;
               rsp_first_moved  <= acc_ff && (cur_ff.x0 != orig_ff.x0 ||
                                              cur_ff.y0 != orig_ff.y0);
               rsp_second_moved <= acc_ff && (cur_ff.x1 != orig_ff.x1 ||
                                              cur_ff.y1 != orig_ff.y1);
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff != S_OUT && rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      end
   end

   // product register between the multiplier and the divider
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) prod_ff <= ma_ff * mb_ff;
   end

endmodule

@@ rtl/line_segment_clipper.sv @@
// Cohen-Sutherland line clipper. A segment word (two signed 32-bit endpoints)
// is accepted on req_valid with req_stall low and lands in a two-word queue
// with its outcodes; the back end clips it against the rectangle held in the
// four csr_ registers (0 x_min, 1 x_max, 2 y_min, 3 y_max). Each edge crossing
// takes a multiply and then a restoring divide, and a segment needs none when
// trivially accepted or rejected and up to 8 crossings at the round cap; the
// back end clips one segment at a time through its single divider.
// Rejected segments come back unchanged with all flags clear. Write the
// csr_ registers only while no segment is in flight.
module line_segment_clipper
   import lsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  coord_type  req_start_x,
   input  coord_type  req_start_y,
   input  coord_type  req_end_x,
   input  coord_type  req_end_y,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output coord_type  rsp_out_start_x,
   output coord_type  rsp_out_start_y,
   output coord_type  rsp_out_end_x,
   output coord_type  rsp_out_end_y,
   output logic       rsp_accepted,
   output logic       rsp_first_moved,
   output logic       rsp_second_moved,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  coord_type  csr_data
);

   rect_type   rect_ff;
   logic       q_valid, q_pop;
   seg_type    q_seg;
   logic [3:0] q_c0, q_c1;

   assign csr_ready = 1'b1;

   // hold the clip rectangle
   always_ff @(posedge clock) begin
      if (reset) rect_ff <= '0;
      else if (csr_valid) begin
         case (csr_index)
            CSR_X_MIN: rect_ff.x_min <= csr_data;
            CSR_X_MAX: rect_ff.x_max <= csr_data;
            CSR_Y_MIN: rect_ff.y_min <= csr_data;
            CSR_Y_MAX: rect_ff.y_max <= csr_data;
            default: ;
         endcase
      end
   end

   lsc_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .rect(rect_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_seg(q_seg), .q_c0(q_c0), .q_c1(q_c1)
   );

   lsc_back u_back (
      .clock(clock), .reset(reset), .rect(rect_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_seg(q_seg), .q_c0(q_c0), .q_c1(q_c1),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_start_x(rsp_out_start_x), .rsp_out_start_y(rsp_out_start_y),
      .rsp_out_end_x(rsp_out_end_x), .rsp_out_end_y(rsp_out_end_y),
      .rsp_accepted(rsp_accepted), .rsp_first_moved(rsp_first_moved),
      .rsp_second_moved(rsp_second_moved)
   );

endmodule
